// File: src/ghi_pkg.sv
// Package for the generalized histogram intersection kernel accumulator.
// Holds payload types, register indexes, the exp2 table and sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ghi_pkg;

   typedef struct packed {
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
      logic               last_term;
   } req_type;

   typedef struct packed {
      logic [47:0] kernel_value;
      logic        saturated;
   } rsp_type;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] REG_POWER_ALPHA = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_POWER_BETA  = 1'd1;
   localparam logic [15:0] POWER_RESET = 16'd4096;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);

   localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOG, ST_MUL, ST_EXP, ST_SUM
   } pow_state_type;

   function automatic logic [31:0] exp_tab(input logic [3:0] k);
      case (k)
         4'd0:    exp_tab = 32'd1518500250;
         4'd1:    exp_tab = 32'd1276901417;
         4'd2:    exp_tab = 32'd1170923762;
         4'd3:    exp_tab = 32'd1121280436;
         4'd4:    exp_tab = 32'd1097253708;
         4'd5:    exp_tab = 32'd1085434106;
         4'd6:    exp_tab = 32'd1079572136;
         4'd7:    exp_tab = 32'd1076653033;
         4'd8:    exp_tab = 32'd1075196443;
         4'd9:    exp_tab = 32'd1074468888;
         4'd10:   exp_tab = 32'd1074105294;
         4'd11:   exp_tab = 32'd1073923544;
         4'd12:   exp_tab = 32'd1073832680;
         4'd13:   exp_tab = 32'd1073787251;
         4'd14:   exp_tab = 32'd1073764537;
         default: exp_tab = 32'd1073753181;
      endcase
   endfunction

endpackage
`default_nettype wire

// File: src/ghi_front.sv
// Front end: accepts pairs and queues them toward the power units.
// Depends on ghi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ghi_front (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_push,
   output logic                req_full,
   input  wire ghi_pkg::req_type req_data,
   output logic                q_valid,
   input  wire logic           q_take,
   output ghi_pkg::req_type    q_data
);
   ghi_pkg::req_type mem_ff [ghi_pkg::FIFO_DEPTH];
   logic [ghi_pkg::FIFO_AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [ghi_pkg::FIFO_AW:0] cnt_ff, cnt_in;
   logic push_ok, take_ok;

   assign req_full = (cnt_ff == (ghi_pkg::FIFO_AW+1)'(ghi_pkg::FIFO_DEPTH));
   assign q_valid  = (cnt_ff != '0);
   assign q_data   = mem_ff[rp_ff];
   assign push_ok  = req_push && !req_full;
   assign take_ok  = q_take && q_valid;

   always_comb begin
      wp_in  = push_ok ? wp_ff + 1'b1 : wp_ff;
      rp_in  = take_ok ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + {{ghi_pkg::FIFO_AW{1'b0}}, push_ok}
                      - {{ghi_pkg::FIFO_AW{1'b0}}, take_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push_ok) mem_ff[wp_ff] <= req_data;
   end

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (ghi_pkg::FIFO_AW+1)'(ghi_pkg::FIFO_DEPTH))
      else $error("queue count overrun");
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      req_full && !take_ok |=> req_full)
      else $error("full dropped without a take");
   a_empty_hold: assert property (@(posedge clock) disable iff (reset)
      !q_valid && !push_ok |=> !q_valid)
      else $error("queue valid without a push");
`endif
endmodule
`default_nettype wire

// File: src/ghi_pow.sv
// Sequential fixed-point power unit: m^e via log2, multiply, exp2.
// One squaring or one table multiply per cycle. Depends on ghi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ghi_pow (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] mag,
   input  wire logic [15:0] expo,
   output logic             done,
   output logic [47:0]      pow,
   output logic             clip
);
   ghi_pkg::pow_state_type st_ff, st_in;
   logic [32:0] z_ff, z_in;
   logic [15:0] frac_ff, frac_in;
   logic [4:0]  p_ff, p_in;
   logic [4:0]  k_ff, k_in;
   logic [15:0] e_ff, e_in;
   logic signed [22:0] logv_ff, logv_in;
   logic signed [39:0] t_ff, t_in;
   logic [31:0] acc_ff, acc_in;
   logic [47:0] pow_ff, pow_in;
   logic clip_ff, clip_in, done_ff, done_in;
   logic [4:0] p_det;
   logic [63:0] sq;
   logic [63:0] am;
   logic signed [39:0] prod;
   logic signed [39:0] tq;
   logic signed [23:0] ip;
   logic [79:0] shl;

   always_comb begin
      p_det = 5'd0;
      for (int i = 0; i < 32; i++) if (mag[i]) p_det = 5'(i);
   end

   assign sq   = z_ff[31:0] * z_ff[31:0];
   assign am   = acc_ff * ghi_pkg::exp_tab(4'(k_ff));
   assign prod = 40'(logv_ff) * $signed({24'd0, e_ff});
   // floor division by 2^12 is an arithmetic shift
   assign tq   = prod >>> 12;
   assign ip   = 24'(t_ff >>> 16);
   assign shl  = {48'd0, acc_ff} << ip[5:0];

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ghi_pkg::ST_IDLE: if (start) begin
            if (expo == 16'd0 || mag == 32'd0) st_in = ghi_pkg::ST_IDLE;
            else st_in = ghi_pkg::ST_LOG;
         end
         ghi_pkg::ST_LOG: if (k_ff == 5'd15) st_in = ghi_pkg::ST_MUL;
         ghi_pkg::ST_MUL: st_in = ghi_pkg::ST_SUM;
         ghi_pkg::ST_SUM: begin
            if (t_ff >= 40'sd2097152 || t_ff < -40'sd1114112) st_in = ghi_pkg::ST_IDLE;
            else st_in = ghi_pkg::ST_EXP;
         end
         ghi_pkg::ST_EXP: if (k_ff == 5'd16) st_in = ghi_pkg::ST_IDLE;
         default: st_in = ghi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      z_in = z_ff; frac_in = frac_ff; p_in = p_ff; k_in = k_ff; e_in = e_ff;
      logv_in = logv_ff; t_in = t_ff; acc_in = acc_ff; pow_in = pow_ff;
      clip_in = clip_ff; done_in = 1'b0;
      case (st_ff)
         ghi_pkg::ST_IDLE: if (start) begin
            e_in = expo; p_in = p_det; k_in = 5'd0; frac_in = '0;
            z_in = {1'b0, mag << (5'd31 - p_det)};
            clip_in = 1'b0;
            if (expo == 16'd0) begin
               pow_in = 48'd65536; done_in = 1'b1;
            end else if (mag == 32'd0) begin
               pow_in = 48'd0; done_in = 1'b1;
            end
         end
         ghi_pkg::ST_LOG: begin
            k_in = k_ff + 5'd1;
            if (sq[63]) begin
               frac_in = {frac_ff[14:0], 1'b1}; z_in = {1'b0, sq[63:32]};
            end else begin
               frac_in = {frac_ff[14:0], 1'b0}; z_in = {1'b0, sq[62:31]};
            end
            if (k_ff == 5'd15)
               logv_in = $signed({2'b0, p_in, 16'd0}) - 23'sd1048576
                         + $signed({7'd0, frac_in});
         end
         ghi_pkg::ST_MUL: t_in = tq;
         ghi_pkg::ST_SUM: begin
            acc_in = 32'h4000_0000; k_in = 5'd0;
            if (t_ff >= 40'sd2097152) begin
               pow_in = ghi_pkg::SUM_MAX; clip_in = 1'b1; done_in = 1'b1;
            end else if (t_ff < -40'sd1114112) begin
               pow_in = 48'd0; done_in = 1'b1;
            end
         end
         ghi_pkg::ST_EXP: begin
            k_in = k_ff + 5'd1;
            if (k_ff != 5'd16) begin
               if (t_ff[5'd15 - k_ff[3:0]]) acc_in = am[61:30];
            end else begin
               done_in = 1'b1;
               if (ip >= 24'sd14) pow_in = shl[61:14];
               else pow_in = 48'(acc_ff >> (6'(24'sd14 - ip)));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ghi_pkg::ST_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         done_ff <= done_in;
      end
      z_ff <= z_in; frac_ff <= frac_in; p_ff <= p_in; k_ff <= k_in; e_ff <= e_in;
      logv_ff <= logv_in; t_ff <= t_in; acc_ff <= acc_in; pow_ff <= pow_in;
      clip_ff <= clip_in;
   end

   assign done = done_ff;
   assign pow  = pow_ff;
   assign clip = clip_ff;

`ifndef NO_ASSERTIONS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |-> st_ff == ghi_pkg::ST_IDLE)
      else $error("power done while busy");
   a_clip_max: assert property (@(posedge clock) disable iff (reset)
      done && clip |-> pow == ghi_pkg::SUM_MAX)
      else $error("clip without max");
   a_log_len: assert property (@(posedge clock) disable iff (reset)
      st_ff == ghi_pkg::ST_LOG |-> k_ff < 5'd16)
      else $error("log count overrun");
`endif
endmodule
`default_nettype wire

// File: src/ghi_back.sv
// Back end: runs two power units, takes the minimum and accumulates.
// Holds one result register toward the output. Depends on ghi_pkg, ghi_pow.
`timescale 1ns / 1ps
`default_nettype none
module ghi_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [15:0]      power_alpha,
   input  wire logic [15:0]      power_beta,
   input  wire logic             q_valid,
   output logic                  q_take,
   input  wire ghi_pkg::req_type q_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output ghi_pkg::rsp_type      rsp_data
);
   logic busy_ff, busy_in, last_ff, last_in;
   logic px_got_ff, px_got_in, py_got_ff, py_got_in;
   logic [47:0] px_ff, px_in, py_ff, py_in;
   logic cx_ff, cx_in, cy_ff, cy_in;
   logic [47:0] sum_ff, sum_in;
   logic ovf_ff, ovf_in;
   logic out_v_ff, out_v_in;
   ghi_pkg::rsp_type out_ff, out_in;
   logic dx, dy, cxo, cyo, start, finish;
   logic [47:0] pxo, pyo, term;
   logic [48:0] nsum;
   logic [31:0] mx, my;

   assign start  = q_valid && !busy_ff;
   // hold a finished last item while the previous result is still unread
   assign finish = busy_ff && px_got_ff && py_got_ff && (!last_ff || !out_v_ff);
   assign q_take = start;
   assign mx = q_data.x_value[31] ? 32'(-q_data.x_value) : q_data.x_value;
   assign my = q_data.y_value[31] ? 32'(-q_data.y_value) : q_data.y_value;

   ghi_pow u_px (.clock, .reset, .start, .mag(mx), .expo(power_alpha),
                 .done(dx), .pow(pxo), .clip(cxo));
   ghi_pow u_py (.clock, .reset, .start, .mag(my), .expo(power_beta),
                 .done(dy), .pow(pyo), .clip(cyo));

   always_comb begin
      busy_in = busy_ff; last_in = last_ff;
      px_got_in = px_got_ff || dx; py_got_in = py_got_ff || dy;
      px_in = dx ? pxo : px_ff; py_in = dy ? pyo : py_ff;
      cx_in = dx ? cxo : cx_ff; cy_in = dy ? cyo : cy_ff;
      sum_in = sum_ff; ovf_in = ovf_ff;
      out_v_in = out_v_ff && !rsp_pop; out_in = out_ff;
      term = (px_ff < py_ff) ? px_ff : py_ff;
      nsum = {1'b0, sum_ff} + {1'b0, term};
      if (start) begin
         busy_in = 1'b1; last_in = q_data.last_term;
         px_got_in = 1'b0; py_got_in = 1'b0;
      end else if (finish) begin
         busy_in = 1'b0; px_got_in = 1'b0; py_got_in = 1'b0;
         sum_in = nsum[48] ? ghi_pkg::SUM_MAX : nsum[47:0];
         ovf_in = ovf_ff || cx_ff || cy_ff || nsum[48];
         if (last_ff) begin
            out_v_in = 1'b1;
            out_in.kernel_value = sum_in;
            out_in.saturated = ovf_in;
            sum_in = '0; ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; px_got_ff <= 1'b0; py_got_ff <= 1'b0;
         sum_ff <= '0; ovf_ff <= 1'b0; out_v_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; px_got_ff <= px_got_in; py_got_ff <= py_got_in;
         sum_ff <= sum_in; ovf_ff <= ovf_in; out_v_ff <= out_v_in;
      end
      last_ff <= last_in; px_ff <= px_in; py_ff <= py_in;
      cx_ff <= cx_in; cy_ff <= cy_in; out_ff <= out_in;
   end

   assign rsp_empty = !out_v_ff;
   assign rsp_data  = out_ff;

`ifndef NO_ASSERTIONS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !q_take)
      else $error("take while busy");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      (dx || dy) |-> busy_ff)
      else $error("power done with no work");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_data))
      else $error("result changed while waiting");
`endif
endmodule
`default_nettype wire

// File: src/ghi_kernel_accumulator.sv
// Generalized histogram intersection kernel accumulator, top level.
// A general pair passes the queue hop, 16 log squarings, the product, range check,
// 16 exp2 steps and shift, capture and sum from accept to result; a trivial or
// out-of-range power finishes early.
// The serial power units take a new pair only once the last one is done; a last pair
// waits while the previous result is unread. Input queue of 4 pairs. Reset
// (synchronous, active high) clears sum, flag and queue; exponents go to 1.0.
`timescale 1ns / 1ps
`default_nettype none
module ghi_kernel_accumulator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire ghi_pkg::req_type                  req_data,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output ghi_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_write,
   input  wire logic [ghi_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  wire logic [ghi_pkg::CSR_DATA_W-1:0]    csr_data
);
   logic [15:0] alpha_ff, beta_ff;
   logic q_valid, q_take;
   ghi_pkg::req_type q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ghi_pkg::POWER_RESET;
         beta_ff  <= ghi_pkg::POWER_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ghi_pkg::REG_POWER_ALPHA: alpha_ff <= csr_data;
            ghi_pkg::REG_POWER_BETA:  beta_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   ghi_front u_front (.clock, .reset, .req_push, .req_full, .req_data,
                      .q_valid, .q_take, .q_data);
   ghi_back u_back (.clock, .reset, .power_alpha(alpha_ff), .power_beta(beta_ff),
                    .q_valid, .q_take, .q_data, .rsp_empty, .rsp_pop, .rsp_data);
endmodule
`default_nettype wire

// File: test/ghi_kernel_accumulator_tb.sv
// Self-checking testbench for ghi_kernel_accumulator: queue-style driver and
// monitor, with an in-bench power/sum predictor checked against every result.
// Depends on ghi_pkg and the ghi_kernel_accumulator RTL.
`timescale 1ns / 1ps
module ghi_kernel_accumulator_tb;

   localparam logic [31:0] EXP2_STEP [16] = '{
      32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436,
      32'd1097253708, 32'd1085434106, 32'd1079572136, 32'd1076653033,
      32'd1075196443, 32'd1074468888, 32'd1074105294, 32'd1073923544,
      32'd1073832680, 32'd1073787251, 32'd1073764537, 32'd1073753181
   };
   localparam int DRAIN_CYCLES = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   ghi_pkg::req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   ghi_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [ghi_pkg::CSR_ADDR_W-1:0] csr_index = ghi_pkg::REG_POWER_ALPHA;
   logic [ghi_pkg::CSR_DATA_W-1:0] csr_data = '0;

   ghi_pkg::req_type pairs_pending[$];
   ghi_pkg::rsp_type kernels_due[$];
   logic [15:0] alpha_now = ghi_pkg::POWER_RESET;
   logic [15:0] beta_now = ghi_pkg::POWER_RESET;
   logic [47:0] sum_now = '0;
   logic overflow_now = 1'b0;
   int error_count = 0;
   int push_gap = 0;
   int pop_stall = 0;

   ghi_kernel_accumulator i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // m^e as exp2(e * log2(m)), bit exact, Q16.16 in and Q32.16 out
   function automatic logic [47:0] powered(input logic [31:0] mag, input logic [15:0] e,
                                           output logic clip);
      int p;
      int k;
      logic [63:0] z;
      logic [63:0] acc;
      logic [15:0] fr;
      longint lg;
      longint prod;
      longint t;
      longint ip;
      clip = 1'b0;
      if (e == 0) return 48'd65536;
      if (mag == 0) return 48'd0;
      p = 31;
      while (p > 0 && !mag[p]) p--;
      z = {32'b0, mag} << (31 - p);
      z = {32'b0, z[31:0]};
      fr = '0;
      for (k = 0; k < 16; k++) begin
         z = (z * z) >> 31;
         fr = {fr[14:0], 1'b0};
         if (z >= 64'h1_0000_0000) begin
            fr[0] = 1'b1;
            z = z >> 1;
         end
      end
      lg = longint'(p - 16) * 65536 + longint'(fr);
      prod = lg * longint'(e);
      t = prod >>> 12;
      if (t >= 32 * 65536) begin
         clip = 1'b1;
         return ghi_pkg::SUM_MAX;
      end
      if (t < -17 * 65536) return 48'd0;
      ip = t >>> 16;
      fr = t[15:0];
      acc = 64'd1 << 30;
      for (k = 0; k < 16; k++)
         if (fr[15 - k]) acc = (acc * {32'b0, EXP2_STEP[k]}) >> 30;
      if (ip >= 14) return 48'(acc << (ip - 14));
      return 48'(acc >> (14 - ip));
   endfunction

   function automatic logic [31:0] magnitude_of(input logic [31:0] raw);
      return raw[31] ? -raw : raw;
   endfunction

   task automatic accumulate_pair(input ghi_pkg::req_type pair);
      logic cx;
      logic cy;
      logic [47:0] px;
      logic [47:0] py;
      logic [48:0] total;
      ghi_pkg::rsp_type kernel;
      px = powered(magnitude_of(pair.x_value), alpha_now, cx);
      py = powered(magnitude_of(pair.y_value), beta_now, cy);
      if (cx || cy) overflow_now = 1'b1;
      total = {1'b0, sum_now} + {1'b0, (px < py) ? px : py};
      if (total > {1'b0, ghi_pkg::SUM_MAX}) begin
         total = {1'b0, ghi_pkg::SUM_MAX};
         overflow_now = 1'b1;
      end
      sum_now = total[47:0];
      if (pair.last_term) begin
         kernel.kernel_value = sum_now;
         kernel.saturated = overflow_now;
         kernels_due.push_back(kernel);
         sum_now = '0;
         overflow_now = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            accumulate_pair(req_data);
            void'(pairs_pending.pop_front());
            push_gap = idle_length();
         end
         if (push_gap > 0) begin
            push_gap--;
            req_push <= 1'b0;
         end else if (pairs_pending.size() > 0) begin
            req_push <= 1'b1;
            req_data <= pairs_pending[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      ghi_pkg::rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (kernels_due.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_data.kernel_value, 48'd0);
            end else begin
               want = kernels_due.pop_front();
               if (rsp_data.kernel_value !== want.kernel_value)
                  report_mismatch("kernel_value", rsp_data.kernel_value, want.kernel_value);
               if (rsp_data.saturated !== want.saturated)
                  report_mismatch("saturated", 48'(rsp_data.saturated), 48'(want.saturated));
            end
            pop_stall = idle_length();
         end
         if (pop_stall > 0) begin
            pop_stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic write_csr(input logic [ghi_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [15:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      if (idx == ghi_pkg::REG_POWER_ALPHA) alpha_now = value;
      else beta_now = value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pairs_pending.size() > 0 || kernels_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_element();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: v = 32'd0;
         1: v = 32'h8000_0000;
         2, 3: v = $urandom;
         4, 5: v = $urandom_range(0, 32'h000F_FFFF);
         6, 7: v = $urandom_range(0, 32'h00FF_FFFF);
         default: v = $urandom_range(32'h0000_8000, 32'h0003_0000);
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   task automatic queue_pair(input logic [31:0] x, input logic [31:0] y, input logic last);
      ghi_pkg::req_type pair;
      pair.x_value = x;
      pair.y_value = y;
      pair.last_term = last;
      pairs_pending.push_back(pair);
   endtask

   task automatic queue_vectors(input int count);
      int n;
      int len;
      n = 0;
      while (n < count) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         for (int i = 0; i < len; i++)
            queue_pair(pick_element(), pick_element(), i == len - 1);
         n += len;
      end
   endtask

   initial begin
      logic [15:0] alphas[6];
      logic [15:0] betas[6];
      alphas = '{16'd4096, 16'd0, 16'd65535, 16'd2048, 16'd1, 16'd0};
      betas  = '{16'd4096, 16'd65535, 16'd0, 16'd6144, 16'd8192, 16'd0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero, most negative, tiny and huge powers
      queue_pair(32'd0, 32'd0, 1'b1);
      queue_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      queue_pair(32'h8000_0000, 32'h8000_0000, 1'b0);
      queue_pair(32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
      queue_pair(32'h0001_0000, 32'hFFFF_0000, 1'b1);
      for (int i = 0; i < 4; i++) queue_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, i == 3);
      wait_idle();
      write_csr(ghi_pkg::REG_POWER_ALPHA, 16'hFFFF);
      write_csr(ghi_pkg::REG_POWER_BETA, 16'hFFFF);
      // huge powers clip; tiny magnitudes underflow to zero
      queue_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      queue_pair(32'h0000_0001, 32'h0000_0002, 1'b1);
      queue_pair(32'h0000_8000, 32'hFFFF_8000, 1'b1);
      queue_pair(32'h0002_0000, 32'h0003_0000, 1'b0);
      queue_pair(32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
      wait_idle();
      write_csr(ghi_pkg::REG_POWER_ALPHA, 16'd0);
      write_csr(ghi_pkg::REG_POWER_BETA, 16'd0);
      // exponent zero gives 1.0 even for zero
      queue_pair(32'd0, 32'h8000_0000, 1'b0);
      queue_pair(32'h1234_5678, 32'd0, 1'b1);
      wait_idle();

      for (int ph = 0; ph < 7; ph++) begin
         if (ph < 6) begin
            write_csr(ghi_pkg::REG_POWER_ALPHA, alphas[ph]);
            write_csr(ghi_pkg::REG_POWER_BETA, betas[ph]);
         end else begin
            write_csr(ghi_pkg::REG_POWER_ALPHA, 16'($urandom_range(0, 16'hFFFF)));
            write_csr(ghi_pkg::REG_POWER_BETA, 16'($urandom_range(0, 16'h3FFF)));
         end
         queue_vectors(62);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
